### hdl/pmpc_pkg.sv
// pmpc_pkg: shared types and constants of the pump level controller
// no dependencies; imported by every module of the block

package pmpc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_LINK_TIMEOUT   = 2'd0;
	localparam logic [1:0] REG_DRY_RUN_LIMIT  = 2'd1;
	localparam logic [1:0] REG_DRY_RUN_ENABLE = 2'd2;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [7:0] LINK_TIMEOUT_RST  = 8'd20;
	localparam logic [7:0] DRY_RUN_LIMIT_RST = 8'd6;
	localparam logic       DRY_RUN_EN_RST    = 1'b1;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	// item mode codes
	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_REPORT = 1'b1;

	// probe level bit positions
	localparam int unsigned LVL_UU = 0;
	localparam int unsigned LVL_UL = 1;
	localparam int unsigned LVL_LU = 2;
	localparam int unsigned LVL_LL = 3;

	// result queue depth and pointer width
	localparam int unsigned QDEPTH = 3;
	localparam int unsigned QPTR_W = 2;

	typedef struct packed {
		logic [7:0] link_timeout;
		logic [7:0] dry_run_limit;
		logic       dry_run_enable;
	} cfg_t;

	typedef struct packed {
		logic       mode;
		logic       phase_a_ok;
		logic       phase_b_ok;
		logic       phase_c_ok;
		logic       flow_sensor;
		logic [1:0] upper_upper_reads;
		logic [1:0] upper_lower_reads;
		logic [1:0] lower_upper_reads;
		logic [1:0] lower_lower_reads;
	} item_t;

	typedef struct packed {
		logic motor_running;
		logic start_pulse;
		logic stop_pulse;
		logic dry_trip;
		logic level_uu;
		logic level_ul;
		logic level_lu;
		logic level_ll;
	} result_t;

endpackage

### hdl/pump_level_controller.sv
// pump_level_controller: top level of the water pump controller
// depends on pmpc_pkg, pmpc_ctrl and pmpc_outq
//
// Usage:
//   item channel (item_valid/item_ready) takes one transaction per cycle while item_ready is high:
//   mode 1 is a probe report that updates the latched tank levels and
//   clears the link-silence count, mode 0 is a control tick that applies
//   the level, power, link and dry-run rules and may pulse start or stop.
//   Every item gives exactly one result on the result channel
//   (result_valid/result_ready) carrying motor state, pulses, trip flag and
//   the four latched levels.
//   The item is registered, the decision is made from the registered item
//   and written to a three-entry result queue, from which the result is
//   offered at the outputs.
//   Throughput is one item per cycle while the receiver keeps up; the queue
//   depth together with the input register sets how many items can be in
//   flight, and item_ready drops when a stalled receiver leaves no room.
//   Configuration (link_timeout, dry_run_limit, dry_run_enable) is written
//   through cfg_we/cfg_index/cfg_wdata; the user must write it only while the
//   block is idle, which the block itself does not enforce; unknown indexes are dropped.
//   Reset clears motor, counters, lockout and levels and loads the register
//   defaults; a dry-run trip holds the motor off until the next reset.

module pump_level_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pmpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pmpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic                              mode,
	input  logic                              phase_a_ok,
	input  logic                              phase_b_ok,
	input  logic                              phase_c_ok,
	input  logic                              flow_sensor,
	input  logic [1:0]                        upper_upper_reads,
	input  logic [1:0]                        upper_lower_reads,
	input  logic [1:0]                        lower_upper_reads,
	input  logic [1:0]                        lower_lower_reads,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              motor_running,
	output logic                              start_pulse,
	output logic                              stop_pulse,
	output logic                              dry_trip,
	output logic                              level_uu,
	output logic                              level_ul,
	output logic                              level_lu,
	output logic                              level_ll
);
	import pmpc_pkg::*;

	cfg_t              cfg_q;
	item_t             item_in;
	item_t             item_s1;
	logic              valid_s1;
	result_t           res;
	result_t           res_out;
	logic [QPTR_W-1:0] q_count;
	logic [QPTR_W:0]   in_flight;
	logic              accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_timeout   <= LINK_TIMEOUT_RST;
			cfg_q.dry_run_limit  <= DRY_RUN_LIMIT_RST;
			cfg_q.dry_run_enable <= DRY_RUN_EN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINK_TIMEOUT:   cfg_q.link_timeout   <= cfg_wdata;
				REG_DRY_RUN_LIMIT:  cfg_q.dry_run_limit  <= cfg_wdata;
				REG_DRY_RUN_ENABLE: cfg_q.dry_run_enable <= cfg_wdata[0];
				default:            ;
			endcase
		end
	end

	assign item_in.mode              = mode;
	assign item_in.phase_a_ok        = phase_a_ok;
	assign item_in.phase_b_ok        = phase_b_ok;
	assign item_in.phase_c_ok        = phase_c_ok;
	assign item_in.flow_sensor       = flow_sensor;
	assign item_in.upper_upper_reads = upper_upper_reads;
	assign item_in.upper_lower_reads = upper_lower_reads;
	assign item_in.lower_upper_reads = lower_upper_reads;
	assign item_in.lower_lower_reads = lower_lower_reads;

	// room for the item in the input register plus queued results
	assign in_flight  = {1'b0, q_count} + {{QPTR_W{1'b0}}, valid_s1};
	assign item_ready = (in_flight < (QPTR_W + 1)'(QDEPTH));
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item_in;
	end

	pmpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.valid  (valid_s1),
		.item   (item_s1),
		.res    (res)
	);

	pmpc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res),
		.pop_ready (result_ready),
		.pop_valid (result_valid),
		.pop_data  (res_out),
		.count     (q_count)
	);

	assign motor_running = res_out.motor_running;
	assign start_pulse   = res_out.start_pulse;
	assign stop_pulse    = res_out.stop_pulse;
	assign dry_trip      = res_out.dry_trip;
	assign level_uu      = res_out.level_uu;
	assign level_ul      = res_out.level_ul;
	assign level_lu      = res_out.level_lu;
	assign level_ll      = res_out.level_ll;

endmodule

### hdl/pmpc_ctrl.sv
// pmpc_ctrl: controller state (motor, counters, lockout, probe levels) and
// the per-transaction decision logic; depends on pmpc_pkg

module pmpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  pmpc_pkg::cfg_t    cfg,
	input  logic              valid,
	input  pmpc_pkg::item_t   item,
	output pmpc_pkg::result_t res
);
	import pmpc_pkg::*;

	logic       running_q, running_d;
	logic [7:0] silence_q, silence_d;
	logic [7:0] dry_q, dry_d;
	logic       locked_q, locked_d;
	logic [3:0] levels_q, levels_d;

	logic       start, stop;
	logic       run_mid;
	logic       level_ok, power_ok, link_ok;
	logic [7:0] sil_adv, dry_adv;

	always_comb begin
		running_d = running_q;
		silence_d = silence_q;
		dry_d     = dry_q;
		locked_d  = locked_q;
		levels_d  = levels_q;
		start     = 1'b0;
		stop      = 1'b0;
		run_mid   = running_q;
		level_ok  = 1'b0;
		power_ok  = 1'b0;
		link_ok   = 1'b0;
		sil_adv   = silence_q;
		dry_adv   = dry_q;
		if (valid) begin
			if (item.mode == MODE_REPORT) begin
				silence_d = '0;
				// first read off means empty, both on means full, glitch holds
				if (!item.upper_lower_reads[0])
					levels_d[LVL_UL] = 1'b0;
				else if (item.upper_lower_reads[1])
					levels_d[LVL_UL] = 1'b1;
				if (!item.upper_upper_reads[0])
					levels_d[LVL_UU] = 1'b0;
				else if (item.upper_upper_reads[1]) begin
					levels_d[LVL_UU] = 1'b1;
					levels_d[LVL_UL] = 1'b1;
				end
				if (!item.lower_lower_reads[0])
					levels_d[LVL_LL] = 1'b0;
				else if (item.lower_lower_reads[1])
					levels_d[LVL_LL] = 1'b1;
				if (!item.lower_upper_reads[0])
					levels_d[LVL_LU] = 1'b0;
				else if (item.lower_upper_reads[1])
					levels_d[LVL_LU] = 1'b1;
			end else if (!locked_q) begin
				if (running_q && silence_q != COUNT_MAX)
					sil_adv = silence_q + 8'd1;
				silence_d = sil_adv;
				if (running_q)
					level_ok = !levels_q[LVL_UU] && levels_q[LVL_LL];
				else
					level_ok = !levels_q[LVL_UU] && !levels_q[LVL_UL] &&
						levels_q[LVL_LU] && levels_q[LVL_LL];
				power_ok = item.phase_a_ok && item.phase_b_ok && item.phase_c_ok;
				link_ok  = (sil_adv <= cfg.link_timeout);
				if (level_ok && power_ok && link_ok) begin
					if (!running_q) begin
						start   = 1'b1;
						run_mid = 1'b1;
					end
				end else if (running_q) begin
					stop    = 1'b1;
					run_mid = 1'b0;
				end
				running_d = run_mid;
				// dry-run supervision on the motor state after the level decision
				if (cfg.dry_run_enable && !item.flow_sensor && run_mid) begin
					if (dry_q != COUNT_MAX)
						dry_adv = dry_q + 8'd1;
					dry_d = dry_adv;
					if (dry_adv > cfg.dry_run_limit) begin
						stop      = 1'b1;
						running_d = 1'b0;
						locked_d  = 1'b1;
					end
				end else begin
					dry_d = '0;
				end
			end
		end
		res.motor_running = running_d;
		res.start_pulse   = start;
		res.stop_pulse    = stop;
		res.dry_trip      = locked_d;
		res.level_uu      = levels_d[LVL_UU];
		res.level_ul      = levels_d[LVL_UL];
		res.level_lu      = levels_d[LVL_LU];
		res.level_ll      = levels_d[LVL_LL];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			silence_q <= '0;
			dry_q     <= '0;
			locked_q  <= 1'b0;
			levels_q  <= '0;
		end else begin
			running_q <= running_d;
			silence_q <= silence_d;
			dry_q     <= dry_d;
			locked_q  <= locked_d;
			levels_q  <= levels_d;
		end
	end

	// lockout is left only through reset
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |=> locked_q)
		else $error("lockout cleared without reset");

	a_locked_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> !running_q)
		else $error("motor running while locked out");

	a_report_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid && item.mode == MODE_REPORT |-> !res.start_pulse && !res.stop_pulse)
		else $error("relay pulse on a probe report");

	a_state_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |=> running_q == $past(running_q) && dry_q == $past(dry_q))
		else $error("state moved without a transaction");

endmodule

### hdl/pmpc_outq.sv
// pmpc_outq: small result queue that decouples the controller from a
// stalled receiver; depends on pmpc_pkg

module pmpc_outq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  pmpc_pkg::result_t           push_data,
	input  logic                        pop_ready,
	output logic                        pop_valid,
	output pmpc_pkg::result_t           pop_data,
	output logic [pmpc_pkg::QPTR_W-1:0] count
);
	import pmpc_pkg::*;

	localparam logic [QPTR_W-1:0] LAST = QPTR_W'(QDEPTH - 1);

	result_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q, cnt_q;
	logic                pop;

	assign pop       = pop_valid && pop_ready;
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != LAST + 1'b1 && cnt_q != LAST + 2'd2 - 1'b1 ||
			cnt_q < LAST)
		else $error("push into a full result queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QPTR_W'(QDEPTH))
		else $error("result queue count out of range");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("count did not advance on push");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("count did not drop on pop");

endmodule
